### rtl/gradient_noise_3d_defines.svh
// Assertion macros shared by the gradient noise checker.
`ifndef GRADIENT_NOISE_3D_DEFINES_SVH
`define GRADIENT_NOISE_3D_DEFINES_SVH

// Check that an antecedent implies a consequent sequence.
`define GN3D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("gn3d check failed");

// Check that an expression holds at every clock edge.
`define GN3D_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("gn3d check failed");

`endif

### rtl/gn3d_pkg.sv
// Shared constants, types and the permutation ROM for the gradient noise block.
package gn3d_pkg;

   localparam int COORD_W   = 32;
   localparam int PERIOD_W  = 9;
   localparam int NOISE_W   = 17;
   localparam int CELL_W    = 8;
   localparam int PERM_SIZE = 256;
   localparam int NOISE_MAX = 65536;

   typedef logic [CELL_W-1:0] cell_type;

   // Gradient selection codes (low four hash bits).
   localparam logic [3:0] GRAD_PX_PY     = 4'h0;
   localparam logic [3:0] GRAD_NX_PY     = 4'h1;
   localparam logic [3:0] GRAD_PX_NY     = 4'h2;
   localparam logic [3:0] GRAD_NX_NY     = 4'h3;
   localparam logic [3:0] GRAD_PX_PZ     = 4'h4;
   localparam logic [3:0] GRAD_NX_PZ     = 4'h5;
   localparam logic [3:0] GRAD_PX_NZ     = 4'h6;
   localparam logic [3:0] GRAD_NX_NZ     = 4'h7;
   localparam logic [3:0] GRAD_PY_PZ     = 4'h8;
   localparam logic [3:0] GRAD_NY_PZ     = 4'h9;
   localparam logic [3:0] GRAD_PY_NZ     = 4'hA;
   localparam logic [3:0] GRAD_NY_NZ     = 4'hB;
   localparam logic [3:0] GRAD_PY_PX     = 4'hC;
   localparam logic [3:0] GRAD_NY_PZ_ALT = 4'hD;
   localparam logic [3:0] GRAD_PY_NX     = 4'hE;
   localparam logic [3:0] GRAD_NY_NZ_ALT = 4'hF;

   localparam cell_type PERM_ROM [PERM_SIZE] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

endpackage

### rtl/gn3d_reduce.sv
// Coordinate reduction: floor modulus by the repeat period, then cell and neighbor index.
module gn3d_reduce #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  vld_in,
   input  logic signed [gn3d_pkg::COORD_W-1:0]   coord,
   input  logic [gn3d_pkg::PERIOD_W-1:0]         period,
   output logic                                  vld_out,
   output gn3d_pkg::cell_type                    cell_idx,
   output gn3d_pkg::cell_type                    cell_next,
   output logic [FRAC_BITS-1:0]                  frac
);

   localparam int NI    = gn3d_pkg::COORD_W - FRAC_BITS;
   localparam int NSTEP = (NI + 1) / 2;
   localparam int MW    = 2 * NSTEP;
   localparam int PW    = gn3d_pkg::PERIOD_W;

   logic [MW-1:0]          mag_ff   [NSTEP+1];
   logic [PW-1:0]          rem_ff   [NSTEP+1];
   logic [PW-1:0]          per_ff   [NSTEP+1];
   logic                   neg_ff   [NSTEP+1];
   gn3d_pkg::cell_type     low_ff   [NSTEP+1];
   logic [FRAC_BITS-1:0]   frac_ff  [NSTEP+1];
   logic [NSTEP:0]         vld_ff;

   logic signed [NI-1:0]   ipart;
   logic [NI-1:0]          mag_in;

   logic                   out_vld_ff;
   gn3d_pkg::cell_type     cell_ff;
   gn3d_pkg::cell_type     next_ff;
   logic [FRAC_BITS-1:0]   out_frac_ff;

   logic [PW-1:0]          rem_last;
   logic [PW-1:0]          rem_fix;
   gn3d_pkg::cell_type     cell_in;
   logic [PW-1:0]          cell_inc;
   gn3d_pkg::cell_type     next_in;

   // One restoring remainder step on one magnitude bit.
   function automatic logic [PW-1:0] rem_step(input logic [PW-1:0] r, input logic b,
                                              input logic [PW-1:0] p);
      logic [PW:0] t;
      t = {r, b};
      if (p != '0 && t >= {1'b0, p}) begin
         t = t - {1'b0, p};
      end
      return t[PW-1:0];
   endfunction

   // Split the integer part into sign and magnitude.
   assign ipart  = coord[gn3d_pkg::COORD_W-1:FRAC_BITS];
   assign mag_in = ipart[NI-1] ? (~ipart + 1'b1) : ipart;

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld_in;
      end
      mag_ff[0]  <= MW'(mag_in);
      rem_ff[0]  <= '0;
      per_ff[0]  <= period;
      neg_ff[0]  <= ipart[NI-1];
      low_ff[0]  <= coord[FRAC_BITS+gn3d_pkg::CELL_W-1:FRAC_BITS];
      frac_ff[0] <= coord[FRAC_BITS-1:0];
   end

   // Remainder stages, two magnitude bits each.
   for (genvar k = 1; k <= NSTEP; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rem_ff[k]  <= rem_step(rem_step(rem_ff[k-1], mag_ff[k-1][MW-1], per_ff[k-1]),
                               mag_ff[k-1][MW-2], per_ff[k-1]);
         mag_ff[k]  <= mag_ff[k-1] << 2;
         per_ff[k]  <= per_ff[k-1];
         neg_ff[k]  <= neg_ff[k-1];
         low_ff[k]  <= low_ff[k-1];
         frac_ff[k] <= frac_ff[k-1];
      end
   end

   // Fold the sign back in and form the neighbor cell.
   always_comb begin
      rem_last = rem_ff[NSTEP];
      rem_fix  = (neg_ff[NSTEP] && rem_last != '0) ? per_ff[NSTEP] - rem_last : rem_last;
      cell_in  = (per_ff[NSTEP] != '0) ? rem_fix[gn3d_pkg::CELL_W-1:0] : low_ff[NSTEP];
      cell_inc = {1'b0, cell_in} + 1'b1;
      next_in  = (per_ff[NSTEP] != '0 && cell_inc == per_ff[NSTEP]) ? '0
                                                                     : cell_inc[gn3d_pkg::CELL_W-1:0];
   end

   // Output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[NSTEP];
      end
      cell_ff     <= cell_in;
      next_ff     <= next_in;
      out_frac_ff <= frac_ff[NSTEP];
   end

   assign vld_out   = out_vld_ff;
   assign cell_idx  = cell_ff;
   assign cell_next = next_ff;
   assign frac      = out_frac_ff;

endmodule

### rtl/gradient_noise_3d.sv
// Top level of the 3D gradient noise pipeline.
// Takes one point per clock: start is accepted whenever busy is low, and busy
// never rises, so a point may be offered every cycle. The result leaves on
// rsp_strobe for one cycle, after the remainder pipeline for the repeat
// period, which settles two integer bits per stage (Q16.16 coordinates by
// default), and then the hash, fade and blend stages. The receiver cannot
// stall, so there is no back pressure anywhere. The repeat period is sampled
// with each point as it enters, and csr_ready is always high.
module gradient_noise_3d #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [gn3d_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [gn3d_pkg::COORD_W-1:0]   req_coord_y,
   input  logic signed [gn3d_pkg::COORD_W-1:0]   req_coord_z,
   output logic                                  rsp_strobe,
   output logic [gn3d_pkg::NOISE_W-1:0]          rsp_noise_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gn3d_pkg::PERIOD_W-1:0]         csr_data
);

   localparam int NSTEP   = (gn3d_pkg::COORD_W - FRAC_BITS + 1) / 2;
   localparam int LATENCY = NSTEP + 13;
   localparam int W       = FRAC_BITS + 6;
   localparam int PW      = 2 * W;
   localparam int SH      = FRAC_BITS + 1 - 16;
   localparam int SHR     = (SH > 0) ? SH : 0;
   localparam int SHL     = (SH < 0) ? -SH : 0;
   localparam int HALF_O  = (SH > 0) ? (1 << (SHR - 1)) : 0;

   localparam logic signed [W-1:0]  ONE_FX  = W'(1 << FRAC_BITS);
   localparam logic signed [W-1:0]  TWO_FX  = W'(2 << FRAC_BITS);
   localparam logic signed [W-1:0]  TEN_FX  = W'(10 << FRAC_BITS);
   localparam logic signed [W-1:0]  FIF_FX  = W'(15 << FRAC_BITS);
   localparam logic signed [PW-1:0] HALF_P  = PW'(1) <<< (FRAC_BITS - 1);

   // Product rounded half up back to the working width.
   function automatic logic signed [W-1:0] fx_round(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = (p + HALF_P) >>> FRAC_BITS;
      return s[W-1:0];
   endfunction

   logic [gn3d_pkg::PERIOD_W-1:0] period_ff;

   logic signed [gn3d_pkg::COORD_W-1:0] coord_in [3];
   logic [2:0]                          red_vld;
   gn3d_pkg::cell_type                  red_cell [3];
   gn3d_pkg::cell_type                  red_next [3];
   logic [FRAC_BITS-1:0]                red_frac [3];

   logic [11:1]                 vld_ff;

   // Fade lanes.
   logic signed [W-1:0]         t_s0   [3];
   logic signed [W-1:0]         poly0  [3];
   logic signed [PW-1:0]        tt1_ff [3];
   logic signed [PW-1:0]        m1_ff  [3];
   logic signed [PW-1:0]        m2_ff  [3];
   logic signed [W-1:0]         ttr2_ff[3];
   logic signed [PW-1:0]        m3_ff  [3];
   logic signed [W-1:0]         fade_ff[3];
   logic signed [W-1:0]         fade_rnd[3];
   logic [FRAC_BITS-1:0]        fr1_ff [3];
   logic [FRAC_BITS-1:0]        fr2_ff [3];
   logic [FRAC_BITS-1:0]        fr3_ff [3];

   // Hash chain.
   gn3d_pkg::cell_type          px1_ff  [2];
   gn3d_pkg::cell_type          yc1_ff  [2];
   gn3d_pkg::cell_type          zc1_ff  [2];
   gn3d_pkg::cell_type          zc2_ff  [2];
   gn3d_pkg::cell_type          pa2_ff  [4];
   gn3d_pkg::cell_type          hash3_ff[8];

   // Gradients and blend tree.
   logic signed [W-1:0]         grad_in [8];
   logic signed [W-1:0]         grad_ff [8];
   logic signed [PW-1:0]        xmul_ff [4];
   logic signed [W-1:0]         xa_ff   [4];
   logic signed [W-1:0]         xl_ff   [4];
   logic signed [W-1:0]         v5_ff, v6_ff;
   logic signed [W-1:0]         w5_ff, w6_ff, w7_ff, w8_ff;
   logic signed [PW-1:0]        ymul_ff [2];
   logic signed [W-1:0]         ya_ff   [2];
   logic signed [W-1:0]         yl_ff   [2];
   logic signed [PW-1:0]        zmul_ff;
   logic signed [W-1:0]         za_ff;
   logic signed [W-1:0]         n_ff;

   logic signed [W-1:0]         out_val;
   logic [31:0]                 out_wide;
   logic [31:0]                 out_shift;
   logic [gn3d_pkg::NOISE_W-1:0] out_ff;

   // Control port: always ready, one register.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_data;
      end
   end

   assign coord_in[0] = req_coord_x;
   assign coord_in[1] = req_coord_y;
   assign coord_in[2] = req_coord_z;

   // Reduce each axis to cell, neighbor cell and fraction.
   for (genvar a = 0; a < 3; a++) begin : g_axis
      gn3d_reduce #(
         .FRAC_BITS (FRAC_BITS)
      ) u_reduce (
         .clock     (clock),
         .reset     (reset),
         .vld_in    (start && !busy),
         .coord     (coord_in[a]),
         .period    (period_ff),
         .vld_out   (red_vld[a]),
         .cell_idx  (red_cell[a]),
         .cell_next (red_next[a]),
         .frac      (red_frac[a])
      );
   end

   // Advance valid bits alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[10:1], red_vld[0]};
      end
   end

   // Fade operand t and the inner polynomial 6t - 15.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         t_s0[a]     = W'(red_frac[a]);
         poly0[a]    = (t_s0[a] <<< 1) + (t_s0[a] <<< 2) - FIF_FX;
         fade_rnd[a] = fx_round(m3_ff[a]);
      end
   end

   // Fade pipeline: t*t and t*(6t - 15), then t*(that + 10), then t*t times that, clamped to [0, 1].
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         tt1_ff[a]  <= t_s0[a] * t_s0[a];
         m1_ff[a]   <= t_s0[a] * poly0[a];
         fr1_ff[a]  <= red_frac[a];
         m2_ff[a]   <= $signed(W'(fr1_ff[a])) * (fx_round(m1_ff[a]) + TEN_FX);
         ttr2_ff[a] <= fx_round(tt1_ff[a]);
         fr2_ff[a]  <= fr1_ff[a];
         m3_ff[a]   <= ttr2_ff[a] * fx_round(m2_ff[a]);
         fr3_ff[a]  <= fr2_ff[a];
         if (fade_rnd[a] < 0) begin
            fade_ff[a] <= '0;
         end else if (fade_rnd[a] > ONE_FX) begin
            fade_ff[a] <= ONE_FX;
         end else begin
            fade_ff[a] <= fade_rnd[a];
         end
      end
   end

   // Hash chain: x lookup, then y, then z for all eight corners.
   always_ff @(posedge clock) begin
      px1_ff[0] <= gn3d_pkg::PERM_ROM[red_cell[0]];
      px1_ff[1] <= gn3d_pkg::PERM_ROM[red_next[0]];
      yc1_ff[0] <= red_cell[1];
      yc1_ff[1] <= red_next[1];
      zc1_ff[0] <= red_cell[2];
      zc1_ff[1] <= red_next[2];
      zc2_ff    <= zc1_ff;
      for (int j = 0; j < 4; j++) begin
         pa2_ff[j] <= gn3d_pkg::PERM_ROM[gn3d_pkg::cell_type'(px1_ff[j[0]] + yc1_ff[j[1]])];
      end
      for (int c = 0; c < 8; c++) begin
         hash3_ff[c] <= gn3d_pkg::PERM_ROM[gn3d_pkg::cell_type'(pa2_ff[c[1:0]] + zc2_ff[c[2]])];
      end
   end

   // Pick the gradient sum for each corner.
   always_comb begin
      logic signed [W-1:0] dx, dy, dz;
      for (int c = 0; c < 8; c++) begin
         dx = c[0] ? W'(fr3_ff[0]) - ONE_FX : W'(fr3_ff[0]);
         dy = c[1] ? W'(fr3_ff[1]) - ONE_FX : W'(fr3_ff[1]);
         dz = c[2] ? W'(fr3_ff[2]) - ONE_FX : W'(fr3_ff[2]);
         case (hash3_ff[c][3:0]) inside
            gn3d_pkg::GRAD_PX_PY, gn3d_pkg::GRAD_PY_PX:     grad_in[c] = dx + dy;
            gn3d_pkg::GRAD_NX_PY:                           grad_in[c] = dy - dx;
            gn3d_pkg::GRAD_PX_NY:                           grad_in[c] = dx - dy;
            gn3d_pkg::GRAD_NX_NY:                           grad_in[c] = -dx - dy;
            gn3d_pkg::GRAD_PX_PZ:                           grad_in[c] = dx + dz;
            gn3d_pkg::GRAD_NX_PZ:                           grad_in[c] = dz - dx;
            gn3d_pkg::GRAD_PX_NZ:                           grad_in[c] = dx - dz;
            gn3d_pkg::GRAD_NX_NZ:                           grad_in[c] = -dx - dz;
            gn3d_pkg::GRAD_PY_PZ:                           grad_in[c] = dy + dz;
            gn3d_pkg::GRAD_NY_PZ, gn3d_pkg::GRAD_NY_PZ_ALT: grad_in[c] = dz - dy;
            gn3d_pkg::GRAD_PY_NZ:                           grad_in[c] = dy - dz;
            gn3d_pkg::GRAD_NY_NZ, gn3d_pkg::GRAD_NY_NZ_ALT: grad_in[c] = -dy - dz;
            gn3d_pkg::GRAD_PY_NX:                           grad_in[c] = dy - dx;
            default:                                        grad_in[c] = '0;
         endcase
      end
   end

   // Blend tree: multiply in one stage, round and add in the next.
   always_ff @(posedge clock) begin
      grad_ff <= grad_in;
      for (int j = 0; j < 4; j++) begin
         xmul_ff[j] <= fade_ff[0] * (grad_ff[2*j+1] - grad_ff[2*j]);
         xa_ff[j]   <= grad_ff[2*j];
         xl_ff[j]   <= xa_ff[j] + fx_round(xmul_ff[j]);
      end
      v5_ff <= fade_ff[1];
      v6_ff <= v5_ff;
      w5_ff <= fade_ff[2];
      w6_ff <= w5_ff;
      w7_ff <= w6_ff;
      w8_ff <= w7_ff;
      for (int k = 0; k < 2; k++) begin
         ymul_ff[k] <= v6_ff * (xl_ff[2*k+1] - xl_ff[2*k]);
         ya_ff[k]   <= xl_ff[2*k];
         yl_ff[k]   <= ya_ff[k] + fx_round(ymul_ff[k]);
      end
      zmul_ff <= w8_ff * (yl_ff[1] - yl_ff[0]);
      za_ff   <= yl_ff[0];
      n_ff    <= za_ff + fx_round(zmul_ff);
   end

   // Map [-1,1] to unsigned Q1.16 of (n+1)/2 with clamp, rounding and saturation.
   always_comb begin
      out_val = n_ff + ONE_FX;
      if (out_val < 0) begin
         out_val = '0;
      end else if (out_val > TWO_FX) begin
         out_val = TWO_FX;
      end
      out_wide  = 32'(unsigned'(out_val));
      out_shift = ((out_wide + 32'(HALF_O)) >> SHR) << SHL;
      if (out_shift > 32'(gn3d_pkg::NOISE_MAX)) begin
         out_shift = 32'(gn3d_pkg::NOISE_MAX);
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_shift[gn3d_pkg::NOISE_W-1:0];
   end

   assign rsp_strobe      = vld_ff[11];
   assign rsp_noise_value = out_ff;

endmodule

### rtl/gn3d_check.sv
// Port-level checker for the gradient noise block, bound to the top level.
`include "gradient_noise_3d_defines.svh"

module gn3d_check #(
   parameter int LATENCY = 21
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [gn3d_pkg::NOISE_W-1:0]  rsp_noise_value
);

   // Every accepted beat comes out after the fixed latency.
   `GN3D_ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##LATENCY rsp_strobe)

   // No result beat without a matching accepted beat.
   `GN3D_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_strobe, $past(start && !busy, LATENCY))

   // Result stays within one.
   `GN3D_ASSERT_ALWAYS(a_range, clock, reset,
      !rsp_strobe || rsp_noise_value <= gn3d_pkg::NOISE_W'(gn3d_pkg::NOISE_MAX))

endmodule

bind gradient_noise_3d gn3d_check #(
   .LATENCY (LATENCY)
) u_gn3d_check (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_noise_value (rsp_noise_value)
);
